[hdl/pbp_pkg.sv]
// Shared types and constants of the particle boundary projection core.
// Used by the top level, the iterative divide/square-root pipeline and the checker.
package pbp_pkg;

  localparam int INDEX_BITS      = 12;
  localparam int DIV_BITS        = 32;
  localparam int CNT_BITS        = 8;
  localparam int COEF_BITS       = 17;
  localparam int SQRT_BITS       = 17;
  localparam int STEPS_PER_STAGE = 4;
  localparam int ITER_STAGES     = DIV_BITS / STEPS_PER_STAGE;
  // input register, iteration stages, limit multiply register, final select into the output register
  localparam int PIPE_LATENCY    = ITER_STAGES + 3;

  typedef enum logic [2:0] {
    CFG_BOUNDARY = 3'd0,
    CFG_AXIS_Y   = 3'd1,
    CFG_ABOVE    = 3'd2,
    CFG_STABLE   = 3'd3,
    CFG_RADIUS   = 3'd4,
    CFG_EPSILON  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [DIV_BITS-1:0]  mag;
    logic [CNT_BITS-1:0]  cnt;
    logic [COEF_BITS-1:0] coef_s;
    logic [COEF_BITS-1:0] coef_k;
  } iter_op_t;

  typedef struct packed {
    logic [DIV_BITS-1:0]  quo;
    logic [SQRT_BITS-1:0] root_s;
    logic [SQRT_BITS-1:0] root_k;
  } iter_res_t;

endpackage

[hdl/pbp_iter_unit.sv]
// Pipelined restoring divider (magnitude / count) and two digit-by-digit square roots.
// Depends on pbp_pkg; four iteration steps per register stage.
module pbp_iter_unit import pbp_pkg::*; (
  input  logic      clk,
  input  iter_op_t  op_i,
  output iter_res_t res_o
);

  typedef struct packed {
    logic [2*SQRT_BITS-1:0] x;
    logic [SQRT_BITS-1:0]   r;
    logic [SQRT_BITS+1:0]   m;
  } sq_t;

  typedef struct packed {
    logic [DIV_BITS-1:0] num;
    logic [DIV_BITS-1:0] quo;
    logic [CNT_BITS-1:0] rem;
    logic [CNT_BITS-1:0] den;
    sq_t                 s;
    sq_t                 k;
  } st_t;

  function automatic st_t div_step(st_t cur);
    logic [CNT_BITS:0] trial;
    st_t o;
    o     = cur;
    trial = {cur.rem, cur.num[DIV_BITS-1]};
    o.num = {cur.num[DIV_BITS-2:0], 1'b0};
    if (trial >= {1'b0, cur.den}) begin
      o.rem = CNT_BITS'(trial - {1'b0, cur.den});
      o.quo = {cur.quo[DIV_BITS-2:0], 1'b1};
    end else begin
      o.rem = trial[CNT_BITS-1:0];
      o.quo = {cur.quo[DIV_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sq_t sq_step(sq_t cur);
    logic [SQRT_BITS+3:0] cat;
    logic [SQRT_BITS+3:0] trial;
    sq_t o;
    cat   = {cur.m, cur.x[2*SQRT_BITS-1 -: 2]};
    trial = {2'b00, cur.r, 2'b01};
    o.x   = {cur.x[2*SQRT_BITS-3:0], 2'b00};
    if (cat >= trial) begin
      o.m = (SQRT_BITS+2)'(cat - trial);
      o.r = {cur.r[SQRT_BITS-2:0], 1'b1};
    end else begin
      o.m = cat[SQRT_BITS+1:0];
      o.r = {cur.r[SQRT_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  st_t init;
  st_t stage_r [ITER_STAGES];

  // Radicand is the coefficient scaled by 2^16, so the root comes out in Q.16.
  always_comb begin
    init.num = op_i.mag;
    init.quo = '0;
    init.rem = '0;
    init.den = op_i.cnt;
    init.s.x = {1'b0, op_i.coef_s, 16'h0000};
    init.s.r = '0;
    init.s.m = '0;
    init.k.x = {1'b0, op_i.coef_k, 16'h0000};
    init.k.r = '0;
    init.k.m = '0;
  end

  for (genvar g = 0; g < ITER_STAGES; g++) begin : g_stage
    st_t stage_in;
    st_t stage_nxt;
    if (g == 0) begin : g_first
      assign stage_in = init;
    end else begin : g_rest
      assign stage_in = stage_r[g-1];
    end
    always_comb begin
      stage_nxt = stage_in;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        stage_nxt = div_step(stage_nxt);
        if (g * STEPS_PER_STAGE + j < SQRT_BITS) begin
          stage_nxt.s = sq_step(stage_nxt.s);
          stage_nxt.k = sq_step(stage_nxt.k);
        end
      end
    end
    always_ff @(posedge clk) begin
      stage_r[g] <= stage_nxt;
    end
  end

  assign res_o.quo    = stage_r[ITER_STAGES-1].quo;
  assign res_o.root_s = stage_r[ITER_STAGES-1].s.r;
  assign res_o.root_k = stage_r[ITER_STAGES-1].k.r;

endmodule

[hdl/particle_boundary_projection_core.sv]
// Top level of the particle boundary projection core: config registers and main pipeline.
// Depends on pbp_pkg and pbp_iter_unit.
//
// One particle enters per clock cycle (busy never rises) and its result appears after the
// start transfer, for one cycle on out_strobe; the receiver cannot stall, so nothing
// ever holds the pipeline. The pipeline depth is set by the divide of the tangential
// displacement by the constraint count: a 32-bit restoring divider spread over eight
// stages of four steps, which also carries both friction square roots. Around it sit
// an input register, a limit-multiply stage and a final select stage.
// Configuration writes are always ready and take effect at once; write them only while
// no particle is in flight.
module particle_boundary_projection_core import pbp_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [INDEX_BITS-1:0]        in_particle_index,
  input  logic signed [31:0]           in_est_x,
  input  logic signed [31:0]           in_est_y,
  input  logic signed [31:0]           in_prev_x,
  input  logic signed [31:0]           in_prev_y,
  input  logic [CNT_BITS-1:0]          in_constraint_count,
  input  logic [COEF_BITS-1:0]         in_static_friction,
  input  logic [COEF_BITS-1:0]         in_kinetic_friction,
  input  logic                         in_is_fluid_or_gas,
  input  logic [15:0]                  in_jitter,
  output logic                         out_strobe,
  output logic [INDEX_BITS-1:0]        out_result_index,
  output logic signed [31:0]           out_new_est_x,
  output logic signed [31:0]           out_new_est_y,
  output logic signed [31:0]           out_new_prev_x,
  output logic signed [31:0]           out_new_prev_y,
  output logic                         out_corrected,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);

  // Particle payload; later fields are filled as the item moves down the pipe.
  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    logic signed [31:0]    est_x;
    logic signed [31:0]    est_y;
    logic signed [31:0]    prev_x;
    logic signed [31:0]    prev_y;
    logic                  fluid;
    logic [17:0]           jv;      // jitter * 3 + 500
    logic [7:0]            jq;      // first guess of jv / 1000
    logic                  neg;     // sign of the tangential displacement
    logic [31:0]           d;       // radius plus jitter offset
    logic                  corr;
    logic signed [31:0]    est_a;   // corrected coordinate on the boundary axis
  } pl_t;

  typedef struct packed {
    pl_t         pl;
    logic [31:0] len;
    logic [32:0] slim;
    logic [32:0] klim;
  } lim_t;

  function automatic logic signed [31:0] sat32(logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Configuration registers
  logic signed [31:0] bnd_r;
  logic               axis_y_r;
  logic               above_r;
  logic               stable_r;
  logic [30:0]        radius_r;
  logic [15:0]        eps_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_r    <= '0;
      axis_y_r <= 1'b0;
      above_r  <= 1'b1;
      stable_r <= 1'b0;
      radius_r <= 31'd16384;
      eps_r    <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BOUNDARY: bnd_r    <= cfg_data;
        CFG_AXIS_Y:   axis_y_r <= cfg_data[0];
        CFG_ABOVE:    above_r  <= cfg_data[0];
        CFG_STABLE:   stable_r <= cfg_data[0];
        CFG_RADIUS:   radius_r <= cfg_data[30:0];
        CFG_EPSILON:  eps_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the payload.
  logic     vld_r [ITER_STAGES+1];
  pl_t      pl_r  [ITER_STAGES+1];
  pl_t      pl0_nxt;
  pl_t      pl1_nxt;
  iter_op_t op_r;
  iter_res_t res;
  logic     lim_vld_r;
  lim_t     lim_r;
  lim_t     lim_nxt;

  // Input stage: tangential difference, jitter scaling first guess.
  logic signed [32:0] diff;
  logic [28:0]        jprod;
  always_comb begin
    diff = axis_y_r ? (33'(in_est_x) - 33'(in_prev_x)) : (33'(in_est_y) - 33'(in_prev_y));
    pl0_nxt        = '0;
    pl0_nxt.idx    = in_particle_index;
    pl0_nxt.est_x  = in_est_x;
    pl0_nxt.est_y  = in_est_y;
    pl0_nxt.prev_x = in_prev_x;
    pl0_nxt.prev_y = in_prev_y;
    pl0_nxt.fluid  = in_is_fluid_or_gas;
    pl0_nxt.jv     = 18'(in_jitter) * 18'd3 + 18'd500;
    // 1048 / 2^20 sits just under 1/1000: the guess is exact or one short
    jprod          = 29'(pl0_nxt.jv) * 29'd1048;
    pl0_nxt.jq     = jprod[27:20];
    pl0_nxt.neg    = diff[32];
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r.mag    <= diff[32] ? 32'(-diff) : diff[31:0];
      op_r.cnt    <= (in_constraint_count == '0) ? CNT_BITS'(1) : in_constraint_count;
      op_r.coef_s <= in_static_friction;
      op_r.coef_k <= in_kinetic_friction;
    end
  end

  pbp_iter_unit u_iter (
    .clk   (clk),
    .op_i  (op_r),
    .res_o (res)
  );

  // Stage 1: finish jitter offset, test the boundary, place the corrected coordinate.
  logic [17:0]        jrem;
  logic [7:0]         extra;
  logic signed [33:0] est_a34;
  logic signed [33:0] bnd34;
  logic signed [33:0] rad34;
  logic signed [33:0] d34;
  always_comb begin
    pl1_nxt = pl_r[0];
    jrem    = pl_r[0].jv - 18'(pl_r[0].jq) * 18'd1000;
    extra   = (jrem >= 18'd1000) ? pl_r[0].jq + 8'd1 : pl_r[0].jq;
    if (!pl_r[0].fluid) extra = '0;
    pl1_nxt.d = 32'(radius_r) + 32'(extra);
    est_a34 = axis_y_r ? 34'(pl_r[0].est_y) : 34'(pl_r[0].est_x);
    bnd34   = 34'(bnd_r);
    rad34   = $signed({3'b000, radius_r});
    d34     = $signed({2'b00, pl1_nxt.d});
    if (above_r) begin
      pl1_nxt.corr  = est_a34 < bnd34 + rad34;
      pl1_nxt.est_a = sat32(bnd34 + d34);
    end else begin
      pl1_nxt.corr  = est_a34 > bnd34 - rad34;
      pl1_nxt.est_a = sat32(bnd34 - d34);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= ITER_STAGES; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
      for (int i = 1; i <= ITER_STAGES; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Capture the payload on a start transfer, then delay it to line up with the
  // divider and square roots.
  always_ff @(posedge clk) begin
    if (start && !busy) pl_r[0] <= pl0_nxt;
    pl_r[1] <= pl1_nxt;
    for (int i = 2; i <= ITER_STAGES; i++) pl_r[i] <= pl_r[i-1];
  end

  // Friction limits: root times offset distance, Q.16 scaled back.
  logic [48:0] sprod;
  logic [48:0] kprod;
  always_comb begin
    sprod        = 49'(res.root_s) * 49'(pl_r[ITER_STAGES].d);
    kprod        = 49'(res.root_k) * 49'(pl_r[ITER_STAGES].d);
    lim_nxt.pl   = pl_r[ITER_STAGES];
    lim_nxt.len  = res.quo;
    lim_nxt.slim = sprod[48:16];
    lim_nxt.klim = kprod[48:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) lim_vld_r <= 1'b0;
    else        lim_vld_r <= vld_r[ITER_STAGES];
    lim_r <= lim_nxt;
  end

  // Final select: boundary coordinate, stable-mode previous move, tangential friction.
  logic signed [31:0] nx_nxt, ny_nxt, px_nxt, py_nxt;
  logic signed [31:0] est_t;
  logic [31:0]        mag;
  logic signed [33:0] t34;
  always_comb begin
    nx_nxt = lim_r.pl.est_x;
    ny_nxt = lim_r.pl.est_y;
    px_nxt = lim_r.pl.prev_x;
    py_nxt = lim_r.pl.prev_y;
    est_t  = axis_y_r ? lim_r.pl.est_x : lim_r.pl.est_y;
    if ({1'b0, lim_r.len} < lim_r.slim) mag = lim_r.len;
    else if (lim_r.klim < {1'b0, lim_r.len}) mag = lim_r.klim[31:0];
    else mag = lim_r.len;
    t34 = lim_r.pl.neg ? 34'(est_t) + $signed({2'b00, mag})
                       : 34'(est_t) - $signed({2'b00, mag});
    if (lim_r.pl.corr) begin
      if (axis_y_r) ny_nxt = lim_r.pl.est_a;
      else          nx_nxt = lim_r.pl.est_a;
      if (stable_r) begin
        if (axis_y_r) py_nxt = lim_r.pl.est_a;
        else          px_nxt = lim_r.pl.est_a;
      end else if (lim_r.len >= 32'(eps_r)) begin
        if (axis_y_r) nx_nxt = sat32(t34);
        else          ny_nxt = sat32(t34);
      end
    end
  end

  // Output register: hold each result for exactly one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= lim_vld_r;
    out_result_index <= lim_r.pl.idx;
    out_new_est_x    <= nx_nxt;
    out_new_est_y    <= ny_nxt;
    out_new_prev_x   <= px_nxt;
    out_new_prev_y   <= py_nxt;
    out_corrected    <= lim_r.pl.corr;
  end

endmodule

[hdl/pbp_checker.sv]
// Port-level checker for the particle boundary projection core, bound to the top level.
// Depends on pbp_pkg for the pipeline latency.
module pbp_checker import pbp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [INDEX_BITS-1:0] in_particle_index,
  input logic signed [31:0]    in_est_x,
  input logic signed [31:0]    in_prev_y,
  input logic                  out_strobe,
  input logic [INDEX_BITS-1:0] out_result_index,
  input logic signed [31:0]    out_new_est_x,
  input logic signed [31:0]    out_new_prev_y,
  input logic                  out_corrected
);

  // every transfer yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##PIPE_LATENCY out_strobe)
    else $error("missing result after transfer");

  // no result without a matching transfer
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(rst_n && start && !busy, PIPE_LATENCY))
    else $error("result without transfer");

  a_index_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_result_index == $past(in_particle_index, PIPE_LATENCY))
    else $error("index mismatch");

  // estimated x and previous y move only on a corrected item
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_corrected |->
      out_new_est_x == $past(in_est_x, PIPE_LATENCY) &&
      out_new_prev_y == $past(in_prev_y, PIPE_LATENCY))
    else $error("uncorrected item changed");

endmodule

bind particle_boundary_projection_core pbp_checker u_pbp_checker (.*);
